// ===== rtl/gpad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gpad_pkg;

   localparam int GP_PLAYER_COUNT = 4;
   localparam int SQRT_STEPS      = 24;
   localparam int DIV_STEPS       = 17;

   localparam logic [14:0] LEFT_DZ_RESET   = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET  = 15'd8689;
   localparam logic [7:0]  TRIG_THR_RESET  = 8'd30;
   localparam logic [14:0] DIR_THR_RESET   = 15'd13107;
   localparam logic [14:0] DZ_FULL         = 15'h7FFF;
   localparam logic [23:0] MC8_MAX         = 24'd8388352;
   localparam logic [15:0] AXIS_CENTRE     = 16'h8000;

   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_THR = 2'd2,
      CSR_DIR_THR  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_DZ,
      OP_CENTRE,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_SCALE,
      OP_NUM,
      OP_DIV_STEP,
      OP_AXIS_STORE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   stick;
      logic   axis;
   } cmd_type;

   typedef struct packed {
      logic centre;
      logic out_free;
   } status_type;

   // raw button bit for priority buttons A..dpad R
   typedef logic [3:0] btn_map_type [14];
   localparam btn_map_type BTN_BIT = '{
      4'd12, 4'd13, 4'd14, 4'd15, 4'd4, 4'd5, 4'd6,
      4'd7,  4'd8,  4'd9,  4'd0,  4'd1, 4'd2, 4'd3
   };

endpackage
`default_nettype wire

// ===== rtl/gpad_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gpad_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         player;
   logic [15:0]        buttons;
   logic [7:0]         l_trig;
   logic [7:0]         r_trig;
   logic signed [15:0] left_x;
   logic signed [15:0] left_y;
   logic signed [15:0] right_x;
   logic signed [15:0] right_y;
   logic               scan_end;

   modport source (output valid, player, buttons, l_trig, r_trig,
                   left_x, left_y, right_x, right_y, scan_end, input ready);
   modport sink (input valid, player, buttons, l_trig, r_trig,
                 left_x, left_y, right_x, right_y, scan_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/gpad_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gpad_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] left_x_out;
   logic [15:0] left_y_out;
   logic [15:0] right_x_out;
   logic [15:0] right_y_out;
   logic [23:0] pressed_mask;
   logic        any_pressed;
   logic [4:0]  first_pressed;
   logic        scan_done;
   logic        scan_hit;
   logic [1:0]  scan_player;
   logic [4:0]  scan_button;

   modport source (output valid, left_x_out, left_y_out, right_x_out, right_y_out,
                   pressed_mask, any_pressed, first_pressed, scan_done, scan_hit,
                   scan_player, scan_button, input ready);
   modport sink (input valid, left_x_out, left_y_out, right_x_out, right_y_out,
                 pressed_mask, any_pressed, first_pressed, scan_done, scan_hit,
                 scan_player, scan_button, output ready);
endinterface
`default_nettype wire

// ===== rtl/gpad_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gpad_dp
   import gpad_pkg::*;
#(
   parameter int PLAYER_COUNT = GP_PLAYER_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gpad_req_if.sink         req_bus,
   gpad_rsp_if.source       rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata,
   input  wire cmd_type     cmd,
   output status_type       sts
);

   logic [14:0] ldz_ff, rdz_ff, dthr_ff;
   logic [7:0]  tthr_ff;

   logic [1:0]         player_ff;
   logic [15:0]        buttons_ff;
   logic [7:0]         lt_ff, rt_ff;
   logic signed [15:0] lx_ff, ly_ff, rx_ff, ry_ff;
   logic               end_ff;

   logic [31:0] acc_ff, acc_in;
   logic [29:0] dz2_ff, dz2_in;
   logic [47:0] nsh_ff, nsh_in;
   logic [25:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic [23:0] e_ff, e_in;
   logic [38:0] den_ff, den_in;
   logic [55:0] drem_ff, drem_in;
   logic [55:0] dsh_ff, dsh_in;
   logic [16:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic [15:0] axout_ff [4];

   logic        rsp_valid_ff;
   logic [15:0] lxo_ff, lyo_ff, rxo_ff, ryo_ff;
   logic [23:0] mask_ff;
   logic        any_ff;
   logic [4:0]  first_ff;
   logic        done_ff, hit_ff;
   logic [1:0]  splayer_ff;
   logic [4:0]  sbutton_ff;

   logic       found_ff;
   logic [1:0] wplayer_ff;
   logic [4:0] wbutton_ff;

   // selected stick, y negated
   logic signed [15:0] raw_x, raw_y;
   logic signed [16:0] x17, y17, vsel;
   logic signed [33:0] sq_x, sq_y;
   logic [14:0]        dz;
   logic [27:0]        sq_pre;
   logic [25:0]        sq_trial;
   logic [23:0]        mc8;
   logic [16:0]        vmag;
   logic [40:0]        prod;
   logic signed [18:0] qs, rsum;
   logic [15:0]        sat;

   assign raw_x = cmd.stick ? rx_ff : lx_ff;
   assign raw_y = cmd.stick ? ry_ff : ly_ff;
   assign x17   = {raw_x[15], raw_x};
   assign y17   = -{raw_y[15], raw_y};
   assign vsel  = cmd.axis ? y17 : x17;
   assign sq_x  = x17 * x17;
   assign sq_y  = y17 * y17;
   assign dz    = cmd.stick ? rdz_ff : ldz_ff;

   assign sq_pre   = {rem_ff, nsh_ff[47:46]};
   assign sq_trial = {root_ff, 2'b01};
   assign mc8      = (root_ff > MC8_MAX) ? MC8_MAX : root_ff;
   assign vmag     = vsel[16] ? 17'(-vsel) : 17'(vsel);
   assign prod     = vmag * e_ff;

   always_comb begin
      qs = neg_ff ? (-$signed({2'b00, quo_ff}) - $signed({18'd0, drem_ff != 56'd0}))
                  : $signed({2'b00, quo_ff});
      rsum = 19'sd32768 + qs;
      if (rsum < 19'sd0) begin
         sat = 16'd0;
      end else if (rsum > 19'sd65535) begin
         sat = 16'hFFFF;
      end else begin
         sat = rsum[15:0];
      end
   end

   assign sts = '{centre:   ({2'b00, dz2_ff} >= acc_ff) || (dz == DZ_FULL),
                  out_free: !rsp_valid_ff || rsp_bus.ready};

   always_comb begin
      acc_in  = acc_ff;
      dz2_in  = dz2_ff;
      nsh_in  = nsh_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      e_in    = e_ff;
      den_in  = den_ff;
      drem_in = drem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      case (cmd.op)
         OP_SQX: acc_in = sq_x[31:0];
         OP_SQY: acc_in = acc_ff + sq_y[31:0];
         OP_DZ:  dz2_in = dz * dz;
         OP_SQRT_INIT: begin
            nsh_in  = {acc_ff, 16'd0};
            rem_in  = '0;
            root_in = '0;
         end
         OP_SQRT_STEP: begin
            nsh_in = {nsh_ff[45:0], 2'b00};
            if (sq_pre >= {2'b00, sq_trial}) begin
               rem_in  = 26'(sq_pre - {2'b00, sq_trial});
               root_in = {root_ff[22:0], 1'b1};
            end else begin
               rem_in  = sq_pre[25:0];
               root_in = {root_ff[22:0], 1'b0};
            end
         end
         OP_SCALE: begin
            e_in   = mc8 - {1'b0, dz, 8'd0};
            den_in = root_ff * (DZ_FULL - dz);
         end
         OP_NUM: begin
            drem_in = {prod, 15'd0};
            dsh_in  = {1'b0, den_ff, 16'd0};
            quo_in  = '0;
            neg_in  = vsel[16];
         end
         OP_DIV_STEP: begin
            dsh_in = {1'b0, dsh_ff[55:1]};
            if (drem_ff >= dsh_ff) begin
               drem_in = drem_ff - dsh_ff;
               quo_in  = {quo_ff[15:0], 1'b1};
            end else begin
               quo_in  = {quo_ff[15:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // item summary
   logic [23:0] mask_c;
   logic [4:0]  first_c;
   logic [16:0] lo_c, hi_c;
   logic        found_c;
   logic [1:0]  wplayer_c;
   logic [4:0]  wbutton_c;

   always_comb begin
      lo_c = 17'd32768 - {2'b00, dthr_ff};
      hi_c = 17'd32768 + {2'b00, dthr_ff};
      mask_c = '0;
      for (int i = 0; i < 14; i++) begin
         mask_c[i] = buttons_ff[BTN_BIT[i]];
      end
      mask_c[14] = lt_ff >= tthr_ff;
      mask_c[15] = rt_ff >= tthr_ff;
      mask_c[16] = {1'b0, axout_ff[1]} < lo_c;
      mask_c[17] = {1'b0, axout_ff[1]} > hi_c;
      mask_c[18] = {1'b0, axout_ff[0]} < lo_c;
      mask_c[19] = {1'b0, axout_ff[0]} > hi_c;
      mask_c[20] = {1'b0, axout_ff[3]} < lo_c;
      mask_c[21] = {1'b0, axout_ff[3]} > hi_c;
      mask_c[22] = {1'b0, axout_ff[2]} < lo_c;
      mask_c[23] = {1'b0, axout_ff[2]} > hi_c;
      first_c = '0;
      for (int i = 23; i >= 0; i--) begin
         if (mask_c[i]) begin
            first_c = 5'(i);
         end
      end
      found_c   = found_ff;
      wplayer_c = wplayer_ff;
      wbutton_c = wbutton_ff;
      if ((mask_c != 24'd0) && !found_ff && ({3'b000, player_ff} < 5'(PLAYER_COUNT))) begin
         found_c   = 1'b1;
         wplayer_c = player_ff;
         wbutton_c = first_c;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      dz2_ff  <= dz2_in;
      nsh_ff  <= nsh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      e_ff    <= e_in;
      den_ff  <= den_in;
      drem_ff <= drem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      if (cmd.op == OP_LOAD) begin
         player_ff  <= req_bus.player;
         buttons_ff <= req_bus.buttons;
         lt_ff      <= req_bus.l_trig;
         rt_ff      <= req_bus.r_trig;
         lx_ff      <= req_bus.left_x;
         ly_ff      <= req_bus.left_y;
         rx_ff      <= req_bus.right_x;
         ry_ff      <= req_bus.right_y;
         end_ff     <= req_bus.scan_end;
      end
      if (cmd.op == OP_CENTRE) begin
         axout_ff[{cmd.stick, 1'b0}] <= AXIS_CENTRE;
         axout_ff[{cmd.stick, 1'b1}] <= AXIS_CENTRE;
      end
      if (cmd.op == OP_AXIS_STORE) begin
         axout_ff[{cmd.stick, cmd.axis}] <= sat;
      end
      if (cmd.op == OP_FINISH) begin
         lxo_ff     <= axout_ff[0];
         lyo_ff     <= axout_ff[1];
         rxo_ff     <= axout_ff[2];
         ryo_ff     <= axout_ff[3];
         mask_ff    <= mask_c;
         any_ff     <= mask_c != 24'd0;
         first_ff   <= first_c;
         done_ff    <= end_ff;
         hit_ff     <= end_ff & found_c;
         splayer_ff <= end_ff ? wplayer_c : 2'd0;
         sbutton_ff <= end_ff ? wbutton_c : 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ldz_ff       <= LEFT_DZ_RESET;
         rdz_ff       <= RIGHT_DZ_RESET;
         tthr_ff      <= TRIG_THR_RESET;
         dthr_ff      <= DIR_THR_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         wplayer_ff   <= '0;
         wbutton_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_LEFT_DZ:  ldz_ff  <= csr_wdata;
               CSR_RIGHT_DZ: rdz_ff  <= csr_wdata;
               CSR_TRIG_THR: tthr_ff <= csr_wdata[7:0];
               CSR_DIR_THR:  dthr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
            found_ff     <= end_ff ? 1'b0 : found_c;
            wplayer_ff   <= end_ff ? 2'd0 : wplayer_c;
            wbutton_ff   <= end_ff ? 5'd0 : wbutton_c;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.left_x_out    = lxo_ff;
   assign rsp_bus.left_y_out    = lyo_ff;
   assign rsp_bus.right_x_out   = rxo_ff;
   assign rsp_bus.right_y_out   = ryo_ff;
   assign rsp_bus.pressed_mask  = mask_ff;
   assign rsp_bus.any_pressed   = any_ff;
   assign rsp_bus.first_pressed = first_ff;
   assign rsp_bus.scan_done     = done_ff;
   assign rsp_bus.scan_hit      = hit_ff;
   assign rsp_bus.scan_player   = splayer_ff;
   assign rsp_bus.scan_button   = sbutton_ff;

endmodule
`default_nettype wire

// ===== rtl/gpad_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gpad_ctrl
   import gpad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   gpad_req_if.sink        req_bus,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQX, S_SQY, S_DZSQ, S_CHECK, S_SQRT,
      S_SCALE, S_NUM, S_DIV, S_STORE, S_FIN
   } state_type;

   state_type  fsm_ff, fsm_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       stick_ff, stick_in;
   logic       axis_ff, axis_in;

   always_comb begin
      fsm_in    = fsm_ff;
      cnt_in    = cnt_ff;
      stick_in  = stick_ff;
      axis_in   = axis_ff;
      cmd.op    = OP_NONE;
      cmd.stick = stick_ff;
      cmd.axis  = axis_ff;
      unique case (fsm_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd.op   = OP_LOAD;
               stick_in = 1'b0;
               axis_in  = 1'b0;
               fsm_in   = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op = OP_SQX;
            fsm_in = S_SQY;
         end
         S_SQY: begin
            cmd.op = OP_SQY;
            fsm_in = S_DZSQ;
         end
         S_DZSQ: begin
            cmd.op = OP_DZ;
            fsm_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.centre) begin
               cmd.op = OP_CENTRE;
               if (stick_ff) begin
                  fsm_in = S_FIN;
               end else begin
                  stick_in = 1'b1;
                  fsm_in   = S_SQX;
               end
            end else begin
               cmd.op = OP_SQRT_INIT;
               cnt_in = '0;
               fsm_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               fsm_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.op  = OP_SCALE;
            axis_in = 1'b0;
            fsm_in  = S_NUM;
         end
         S_NUM: begin
            cmd.op = OP_NUM;
            cnt_in = '0;
            fsm_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               fsm_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op = OP_AXIS_STORE;
            if (!axis_ff) begin
               axis_in = 1'b1;
               fsm_in  = S_NUM;
            end else if (!stick_ff) begin
               stick_in = 1'b1;
               fsm_in   = S_SQX;
            end else begin
               fsm_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.op = OP_FINISH;
               fsm_in = S_IDLE;
            end
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= S_IDLE;
         cnt_ff   <= '0;
         stick_ff <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         fsm_ff   <= fsm_in;
         cnt_ff   <= cnt_in;
         stick_ff <= stick_in;
         axis_ff  <= axis_in;
      end
   end

   assign req_bus.ready = (fsm_ff == S_IDLE);

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (fsm_ff == S_SQX && !stick_ff))
      else $error("item accept did not start left stick");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) |-> sts.out_free)
      else $error("result loaded over pending item");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_DIV) |-> (cnt_ff < 5'(DIV_STEPS)))
      else $error("divide step count overran");
`endif

endmodule
`default_nettype wire

// ===== rtl/gamepad_stick_deadzone_button_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// When both sticks sit in their deadzone, no square root or divide is run;
// at most, both sticks need the 24-step square root and two 17-step divides
// each, all on one shared bit-serial sqrt/divide datapath.
// One item is handled at a time: the result waits for a free output register,
// and the next item is taken once it is there. Synchronous reset restores the
// register defaults and clears the scan state and the output valid.
module gamepad_stick_deadzone_button_scan
   import gpad_pkg::*;
#(
   parameter int PLAYER_COUNT = GP_PLAYER_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gpad_req_if.sink         req_bus,
   gpad_rsp_if.source       rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   gpad_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .sts     (sts),
      .cmd     (cmd)
   );

   gpad_dp #(
      .PLAYER_COUNT (PLAYER_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire
